// ===== hw/rtl/qte_pkg.sv =====
`timescale 1ns / 1ps
package qte_pkg;

    localparam int DATA_W        = 16;
    localparam int CW            = 36;
    localparam int ANG_W         = 32;
    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ROOT_W        = 29;
    localparam int RAD_W         = 57;
    localparam int SPM_W         = 29;
    localparam int SQ_W          = 56;
    localparam int PROD_W        = 33;
    localparam int LOCK_LIMIT    = 268408612;
    localparam int HALF_Q28      = 134217728;
    localparam int PITCH_MAX     = 16384;

    function automatic logic [ANG_W-1:0] atan_entry(input int idx);
        logic [ANG_W-1:0] r;
        unique case (idx)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/qte_sqrt.sv =====
`timescale 1ns / 1ps
module qte_sqrt (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [qte_pkg::RAD_W-1:0]   rad,
    output logic [qte_pkg::ROOT_W-1:0]  root
);
    import qte_pkg::*;

    localparam int TW = RAD_W + 2;

    logic [RAD_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];

    always_comb begin
        rem_reg[0]  = rad;
        root_reg[0] = '0;
    end

    // one result bit per stage, MSB first
    for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
        localparam int K = ROOT_W - 1 - j;
        logic [TW-1:0] trial;
        logic          take;
        assign trial = (TW'(root_reg[j]) << (K + 1)) + (TW'(1) << (2 * K));
        assign take  = trial <= TW'(rem_reg[j]);
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= take ? RAD_W'(TW'(rem_reg[j]) - trial) : rem_reg[j];
                root_reg[j+1] <= take ? (root_reg[j] | (ROOT_W'(1) << K)) : root_reg[j];
            end
        end
    end

    assign root = root_reg[ROOT_W];

endmodule

// ===== hw/rtl/qte_cordic.sv =====
`timescale 1ns / 1ps
module qte_cordic #(
    parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [qte_pkg::CW-1:0]     vec_y,
    input  logic signed [qte_pkg::CW-1:0]     vec_x,
    output logic signed [qte_pkg::DATA_W-1:0] angle
);
    import qte_pkg::*;

    logic signed [CW-1:0]    x_reg [0:STEPS];
    logic signed [CW-1:0]    y_reg [0:STEPS];
    logic        [ANG_W-1:0] z_reg [0:STEPS];
    logic                    zero_reg [0:STEPS];
    logic        [ANG_W-1:0] z_rnd;
    logic signed [DATA_W-1:0] angle_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (vec_x == '0) && (vec_y == '0);
            if (vec_x < 0) begin
                if (vec_y >= 0) begin
                    x_reg[0] <= vec_y;
                    y_reg[0] <= -vec_x;
                    z_reg[0] <= 32'h4000_0000;
                end else begin
                    x_reg[0] <= -vec_y;
                    y_reg[0] <= vec_x;
                    z_reg[0] <= 32'hC000_0000;
                end
            end else begin
                x_reg[0] <= vec_x;
                y_reg[0] <= vec_y;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
            end
        end
    end

    assign z_rnd = z_reg[STEPS] + 32'h0000_8000;

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= zero_reg[STEPS] ? '0 : $signed(z_rnd[ANG_W-1:ANG_W-DATA_W]);
        end
    end

    assign angle = angle_reg;

endmodule

// ===== hw/rtl/quaternion_to_euler_angles_core.sv =====
`timescale 1ns / 1ps
// The input beat passes the 29-stage square root ahead of the CORDIC stages on its
// way to the output beat.
// Throughput: one beat per cycle; the whole pipeline advances when the output
// register is empty or taken.
// Reset (aresetn low, synchronous) clears all valid bits and frame_direction.
module quaternion_to_euler_angles_core #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // heading_angle, pitch_angle, bank_angle
    output logic        m_tuser    // gimbal_lock
);
    import qte_pkg::*;

    localparam int LAT = 37 + CORDIC_STEPS;
    localparam int DL  = 2 + ROOT_W;
    localparam int LL  = CORDIC_STEPS + 2;

    typedef struct packed {
        logic signed [CW-1:0]     sp;
        logic signed [CW-1:0]     hy;
        logic signed [CW-1:0]     hx;
        logic signed [CW-1:0]     by;
        logic signed [CW-1:0]     bx;
        logic                     lock;
        logic signed [DATA_W-1:0] plock;
    } mid_t;

    typedef struct packed {
        logic                     lock;
        logic signed [DATA_W-1:0] plock;
    } lk_t;

    localparam logic signed [CW-1:0] HALF = CW'(HALF_Q28);
    localparam logic signed [CW-1:0] LIM  = CW'(LOCK_LIMIT);
    localparam logic signed [CW-1:0] PMAX = CW'(PITCH_MAX);

    logic dir_reg;
    logic vld_reg [0:LAT-1];
    logic en;

    logic signed [DATA_W:0]   w1_reg;
    logic signed [DATA_W-1:0] x1_reg, y1_reg, z1_reg;
    logic signed [PROD_W-1:0] xz_reg, wy_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] yz_reg, wx_reg, xy_reg, wz_reg;
    mid_t                     s3_next, s3_reg;
    logic signed [SPM_W-1:0]  spm_reg;
    logic signed [CW-1:0]     spd, psh;
    logic signed [2*SPM_W-1:0] sqf;
    logic [SQ_W-1:0]          sq_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic [ROOT_W-1:0]        root;
    mid_t                     dl_reg [0:DL-1];
    lk_t                      ll_reg [0:LL-1];
    logic signed [DATA_W-1:0] head_a, pitch_a, bank_a;
    logic [47:0]              out_reg;
    logic                     lock_out_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = out_reg;
    assign m_tuser  = lock_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= 1'b0;
        end else if (cfg_we) begin
            dir_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LAT; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_comb begin
        spd = CW'(wx_reg) - CW'(yz_reg);
        s3_next.sp   = spd + spd;
        s3_next.lock = (s3_next.sp > LIM) || (s3_next.sp < -LIM);
        if (s3_next.lock) begin
            s3_next.hy = CW'(wy_reg) - CW'(xz_reg);
            s3_next.hx = HALF - CW'(yy_reg) - CW'(zz_reg);
        end else begin
            s3_next.hy = CW'(xz_reg) + CW'(wy_reg);
            s3_next.hx = HALF - CW'(xx_reg) - CW'(yy_reg);
        end
        s3_next.by = CW'(xy_reg) + CW'(wz_reg);
        s3_next.bx = HALF - CW'(xx_reg) - CW'(zz_reg);
        psh = (s3_next.sp + CW'(8192)) >>> 14;
        if (psh > PMAX)       s3_next.plock = DATA_W'(PITCH_MAX);
        else if (psh < -PMAX) s3_next.plock = -DATA_W'(PITCH_MAX);
        else                  s3_next.plock = psh[DATA_W-1:0];
    end

    assign sqf = (2*SPM_W)'(spm_reg) * (2*SPM_W)'(spm_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            w1_reg <= dir_reg ? -(DATA_W+1)'($signed(s_tdata[15:0]))
                              :  (DATA_W+1)'($signed(s_tdata[15:0]));
            x1_reg <= $signed(s_tdata[31:16]);
            y1_reg <= $signed(s_tdata[47:32]);
            z1_reg <= $signed(s_tdata[63:48]);

            xz_reg <= PROD_W'(x1_reg) * PROD_W'(z1_reg);
            wy_reg <= PROD_W'(w1_reg) * PROD_W'(y1_reg);
            xx_reg <= PROD_W'(x1_reg) * PROD_W'(x1_reg);
            yy_reg <= PROD_W'(y1_reg) * PROD_W'(y1_reg);
            zz_reg <= PROD_W'(z1_reg) * PROD_W'(z1_reg);
            yz_reg <= PROD_W'(y1_reg) * PROD_W'(z1_reg);
            wx_reg <= PROD_W'(w1_reg) * PROD_W'(x1_reg);
            xy_reg <= PROD_W'(x1_reg) * PROD_W'(y1_reg);
            wz_reg <= PROD_W'(w1_reg) * PROD_W'(z1_reg);

            s3_reg  <= s3_next;
            spm_reg <= s3_next.lock ? '0 : s3_next.sp[SPM_W-1:0];

            sq_reg  <= sqf[SQ_W-1:0];
            rad_reg <= (RAD_W'(1) << SQ_W) - RAD_W'(sq_reg);

            dl_reg[0] <= s3_reg;
            for (int i = 1; i < DL; i++) dl_reg[i] <= dl_reg[i-1];

            ll_reg[0] <= '{lock: dl_reg[DL-1].lock, plock: dl_reg[DL-1].plock};
            for (int i = 1; i < LL; i++) ll_reg[i] <= ll_reg[i-1];

            out_reg <= {ll_reg[LL-1].lock ? DATA_W'(0) : bank_a,
                        ll_reg[LL-1].lock ? ll_reg[LL-1].plock : pitch_a,
                        head_a};
            lock_out_reg <= ll_reg[LL-1].lock;
        end
    end

    qte_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (rad_reg),
        .root (root)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_head (
        .aclk  (aclk),
        .en    (en),
        .vec_y (dl_reg[DL-1].hy),
        .vec_x (dl_reg[DL-1].hx),
        .angle (head_a)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .aclk  (aclk),
        .en    (en),
        .vec_y (dl_reg[DL-1].sp),
        .vec_x ($signed(CW'(root))),
        .angle (pitch_a)
    );

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_bank (
        .aclk  (aclk),
        .en    (en),
        .vec_y (dl_reg[DL-1].by),
        .vec_x (dl_reg[DL-1].bx),
        .angle (bank_a)
    );

    a_lock_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[47:32] == '0)
        else $error("bank not zero in gimbal lock");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd16384) &&
                     ($signed(m_tdata[31:16]) >= -16'sd16384))
        else $error("pitch out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

// ===== tb/tb_quaternion_to_euler_angles_core.sv =====
`timescale 1ns / 1ps
module tb_quaternion_to_euler_angles_core;

    localparam int STEPS     = qte_pkg::CORDIC_STEPS_DEF;
    localparam int LATENCY   = 37 + STEPS;
    localparam int N_RANDOM  = 1250;

    typedef struct packed {
        logic [15:0] bank;
        logic [15:0] pitch;
        logic [15:0] heading;
        logic        lock;
    } euler_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    quaternion_to_euler_angles_core DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [63:0] quat_queue[$];
    euler_t      angle_queue[$];
    logic        inverse_frame = 1'b0;
    int          errors = 0;
    int          n_beats = 0;
    int          n_lock = 0;
    int          idle_cycles = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          sink_hold = 1'b0;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] vector_angle(longint y, longint x);
        logic [31:0] acc;
        longint dx, dy, t;
        acc = '0;
        if (x == 0 && y == 0)
            return 16'd0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; acc = 32'h4000_0000;
            end else begin
                x = -y; y = t; acc = 32'hC000_0000;
            end
        end
        for (int i = 0; i < STEPS && i < qte_pkg::ATAN_LEN; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; acc += qte_pkg::atan_entry(i);
            end else begin
                x -= dx; y += dy; acc -= qte_pkg::atan_entry(i);
            end
        end
        acc = acc + 32'h8000;
        return acc[31:16];
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic euler_t quat_to_euler(logic [63:0] q);
        euler_t r;
        longint w, x, y, z, sp, p, c;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        if (inverse_frame) w = -w;
        sp = -2 * (y * z - w * x);
        if (sp > qte_pkg::LOCK_LIMIT || sp < -qte_pkg::LOCK_LIMIT) begin
            p = floor_shr(sp + 8192, 14);
            if (p > qte_pkg::PITCH_MAX) p = qte_pkg::PITCH_MAX;
            if (p < -qte_pkg::PITCH_MAX) p = -qte_pkg::PITCH_MAX;
            r.heading = vector_angle(-x * z + w * y, qte_pkg::HALF_Q28 - y * y - z * z);
            r.pitch = p[15:0];
            r.bank = '0;
            r.lock = 1'b1;
        end else begin
            c = int_sqrt((64'd1 << 56) - longint'(sp * sp));
            r.heading = vector_angle(x * z + w * y, qte_pkg::HALF_Q28 - x * x - y * y);
            r.pitch = vector_angle(sp, c);
            r.bank = vector_angle(x * y + w * z, qte_pkg::HALF_Q28 - x * x - z * z);
            r.lock = 1'b0;
        end
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                angle_queue.push_back(quat_to_euler(s_tdata));
                void'(quat_queue.pop_front());
            end
            if ((s_tvalid && !s_tready) ) begin
                // hold current beat
            end else if (quat_queue.size() > (s_tvalid && s_tready ? 0 : 0) &&
                         !(src_idle_on && $urandom_range(99) < 28)) begin
                s_tvalid <= 1'b1;
                s_tdata <= quat_queue[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        euler_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.heading = m_tdata[15:0];
                got.pitch = m_tdata[31:16];
                got.bank = m_tdata[47:32];
                got.lock = m_tuser;
                n_beats++;
                if (got.lock) n_lock++;
                if (angle_queue.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat %h lock %b", $time, m_tdata, m_tuser);
                end else begin
                    want = angle_queue.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch exp h=%h p=%h b=%h l=%b got h=%h p=%h b=%h l=%b",
                            $time, want.heading, want.pitch, want.bank, want.lock,
                            got.heading, got.pitch, got.bank, got.lock);
                    end
                end
            end
            m_tready <= !sink_hold && !(sink_idle_on && $urandom_range(99) < 28);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || sink_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LATENCY * 20 + 2000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (quat_queue.size() != 0 || s_tvalid || angle_queue.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic set_direction(logic v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        inverse_frame = v;
    endtask

    function automatic logic [15:0] rand_comp();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 16'($urandom);
        if (k == 1) return 16'($urandom_range(2) == 0 ? 16384 : -16384);
        return 16'($urandom_range(32768) - 16384);
    endfunction

    // random quaternion: mostly near-unit, sometimes raw random components, optionally near gimbal lock
    function automatic logic [63:0] rand_quat();
        real a, b, c, d, n;
        int k;
        k = $urandom_range(99);
        if (k < 10)
            return {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        a = real'($urandom_range(2000)) - 1000.0;
        b = real'($urandom_range(2000)) - 1000.0;
        c = real'($urandom_range(2000)) - 1000.0;
        d = real'($urandom_range(2000)) - 1000.0;
        if (k < 30) begin
            // make x = w with jitter, and z = -y with jitter or z = y
            b = a + real'($urandom_range(6)) - 3.0;
            d = -c + real'($urandom_range(6)) - 3.0;
            if ($urandom_range(1)) d = c;
        end
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) n = 1.0;
        return {16'($rtoi(d / n * 16384.0)), 16'($rtoi(c / n * 16384.0)),
                16'($rtoi(b / n * 16384.0)), 16'($rtoi(a / n * 16384.0))};
    endfunction

    task automatic load_directed();
        logic [15:0] P, N, Z, H;
        P = 16'sd16384; N = -16'sd16384; Z = '0; H = 16'd11585;
        quat_queue.push_back({Z, Z, Z, Z});
        quat_queue.push_back({Z, Z, Z, P});
        quat_queue.push_back({Z, Z, Z, N});
        quat_queue.push_back({Z, Z, P, Z});
        quat_queue.push_back({Z, P, Z, Z});
        quat_queue.push_back({P, Z, Z, Z});
        quat_queue.push_back({Z, Z, H, H});
        quat_queue.push_back({Z, Z, -H, H});
        quat_queue.push_back({H, H, Z, Z});
        quat_queue.push_back({16'h2000, 16'h2000, 16'h2000, 16'h2000});
        quat_queue.push_back({16'he000, 16'h2000, 16'he000, 16'h2000});
        quat_queue.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000});
        quat_queue.push_back({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
        quat_queue.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        quat_queue.push_back({16'hffff, 16'hffff, 16'hffff, 16'hffff});
        quat_queue.push_back({Z, P, Z, N});
        quat_queue.push_back({N, Z, P, Z});
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (int d = 0; d < 2; d++) begin
            set_direction(d[0]);
            load_directed();
            wait_drained();
        end
        for (int ph = 0; ph < 4; ph++) begin
            set_direction(ph[0] ^ ph[1]);
            src_idle_on = (ph != 2);
            sink_idle_on = (ph != 2);
            for (int i = 0; i < N_RANDOM / 4; i++)
                quat_queue.push_back(rand_quat());
            if (ph == 1) begin
                repeat (30) @(posedge aclk);
                sink_hold = 1'b1;
                repeat (LATENCY * 3) @(posedge aclk);
                sink_hold = 1'b0;
            end
            wait_drained();
        end
        $display("Checked %0d result beats (%0d in gimbal lock) across both frame directions,",
            n_beats, n_lock);
        $display("with directed extremes, random quaternions and a long output stall.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/qte_pkg.sv
hw/rtl/qte_sqrt.sv
hw/rtl/qte_cordic.sv
hw/rtl/quaternion_to_euler_angles_core.sv
tb/tb_quaternion_to_euler_angles_core.sv
